// File: rtl/bafe_pkg.sv
`timescale 1ns / 1ps

package bafe_pkg;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TICK    = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  localparam int unsigned WinLen   = 11;
  localparam int unsigned FrameLen = 8;

  localparam logic [7:0] HostStx   = 8'h02;
  localparam logic [7:0] HostLen   = 8'h08;
  localparam logic [7:0] HostEtx   = 8'h03;
  localparam logic [7:0] CtrlFirst = 8'h11;
  localparam logic [7:0] CtrlOther = 8'h10;

  localparam logic [6:0] ReplyStx = 7'h02;
  localparam logic [6:0] ReplyLen = 7'h0B;
  localparam logic [6:0] ReplyEtx = 7'h03;

  localparam logic [15:0] TimeoutReset = 16'd200;

endpackage

// File: rtl/bill_acceptor_frame_engine.sv
`timescale 1ns / 1ps

// Host-side framing engine for a bill acceptor link.
// Input channel (in_valid/in_ready): one item per transfer. A request item
// produces eight transmit results (the host frame, last_of_frame on byte
// eight). A received byte is shifted into an 11-byte window and yields one
// reply result when the window first holds a valid reply. A timer tick
// yields one timeout result when the reply wait runs out.
// Output channel (out_valid/out_ready): one result per transfer.
// Latency: a result is presented in the cycle after its item's transfer.
// Throughput: one item per cycle, but an item with a result waits while one
// is pending; a request holds the result register for eight output transfers,
// one byte per cycle while out_ready is high. Items with no result never wait.
// When the receiver stalls, the pending result holds; items without results
// keep being accepted, and an item with a result is accepted in the cycle
// the last pending result transfers.
// cfg_wr_en/cfg_wr_data load the reply timeout in ticks (reset value 200).
// Reset is synchronous: no result pending, no reply awaited, control byte
// 0x11 first, empty receive window.
module bill_acceptor_frame_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  request_byte_a,
  input  logic [7:0]  request_byte_b,
  input  logic [7:0]  request_byte_c,
  input  logic [7:0]  received_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  transmit_byte,
  output logic        last_of_frame,
  output logic [6:0]  reply_state,
  output logic [6:0]  reply_id,
  output logic [6:0]  reply_bill_type,
  output logic [6:0]  reply_extra_a,
  output logic [6:0]  reply_extra_b,
  output logic [6:0]  reply_extra_c
);

  logic [15:0] timeout_ticks;
  logic        sequence_toggle;
  logic [6:0]  win [bafe_pkg::WinLen];
  logic [3:0]  window_fill;
  logic        awaiting_reply;
  logic [15:0] timeout_counter;

  logic                pend_valid;
  bafe_pkg::kind_t     pend_kind;
  logic [2:0]          pend_idx;
  logic [7:0]          pend_a;
  logic [7:0]          pend_b;
  logic [7:0]          pend_c;
  logic [7:0]          pend_ctrl;
  logic [7:0]          pend_chk;
  logic [6:0]          pend_reply [6];

  bafe_pkg::opcode_t op;
  logic [6:0]        win_next [bafe_pkg::WinLen];
  logic [3:0]        fill_next;
  logic [6:0]        win_xor;
  logic              win_ok;
  logic              reply_hit;
  logic              timeout_hit;
  logic              produces;
  logic              drain_done;
  logic              in_fire;
  logic              out_fire;
  logic [7:0]        ctrl_byte;

  assign op = bafe_pkg::opcode_t'(opcode);

  // Window as it stands after the incoming byte is shifted in.
  always_comb begin
    for (int i = 0; i < bafe_pkg::WinLen - 1; i++) begin
      win_next[i] = win[i + 1];
    end
    win_next[bafe_pkg::WinLen - 1] = received_byte[6:0];
    fill_next = (window_fill < 4'(bafe_pkg::WinLen)) ? window_fill + 4'd1 : window_fill;
    win_xor = 7'd0;
    for (int i = 1; i <= 8; i++) begin
      win_xor = win_xor ^ win_next[i];
    end
    win_ok = (fill_next == 4'(bafe_pkg::WinLen)) &&
             (win_next[0] == bafe_pkg::ReplyStx) &&
             (win_next[1] == bafe_pkg::ReplyLen) &&
             (win_next[9] == bafe_pkg::ReplyEtx) &&
             (win_next[10] == win_xor);
  end

  assign ctrl_byte   = sequence_toggle ? bafe_pkg::CtrlOther : bafe_pkg::CtrlFirst;
  assign reply_hit   = (op == bafe_pkg::OP_BYTE) && awaiting_reply && win_ok;
  assign timeout_hit = (op == bafe_pkg::OP_TICK) && awaiting_reply &&
                       (timeout_counter <= 16'd1);
  assign produces    = (op == bafe_pkg::OP_REQUEST) || reply_hit || timeout_hit;

  assign out_fire   = pend_valid && out_ready;
  assign drain_done = out_fire && ((pend_kind != bafe_pkg::KIND_TX) || (pend_idx == 3'd7));
  assign in_ready   = !pend_valid || drain_done || !produces;
  assign in_fire    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= bafe_pkg::TimeoutReset;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  // Link state, updated only on input transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_toggle <= 1'b0;
      window_fill     <= 4'd0;
      awaiting_reply  <= 1'b0;
      timeout_counter <= 16'd0;
      for (int i = 0; i < bafe_pkg::WinLen; i++) begin
        win[i] <= 7'd0;
      end
    end else if (in_fire) begin
      case (op)
        bafe_pkg::OP_REQUEST: begin
          sequence_toggle <= ~sequence_toggle;
          window_fill     <= 4'd0;
          awaiting_reply  <= 1'b1;
          timeout_counter <= timeout_ticks;
          for (int i = 0; i < bafe_pkg::WinLen; i++) begin
            win[i] <= 7'd0;
          end
        end
        bafe_pkg::OP_BYTE: begin
          win         <= win_next;
          window_fill <= fill_next;
          if (reply_hit) begin
            awaiting_reply <= 1'b0;
          end
        end
        bafe_pkg::OP_TICK: begin
          if (timeout_hit) begin
            awaiting_reply  <= 1'b0;
            timeout_counter <= 16'd0;
          end else if (awaiting_reply) begin
            timeout_counter <= timeout_counter - 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: holds one pending result group and walks frame bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_idx   <= 3'd0;
      pend_kind  <= bafe_pkg::KIND_TX;
    end else begin
      if (drain_done) begin
        pend_valid <= 1'b0;
      end else if (out_fire) begin
        pend_idx <= pend_idx + 3'd1;
      end
      if (in_fire && produces) begin
        pend_valid <= 1'b1;
        pend_idx   <= 3'd0;
        if (op == bafe_pkg::OP_REQUEST) begin
          pend_kind <= bafe_pkg::KIND_TX;
        end else if (reply_hit) begin
          pend_kind <= bafe_pkg::KIND_REPLY;
        end else begin
          pend_kind <= bafe_pkg::KIND_TIMEOUT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (op == bafe_pkg::OP_REQUEST)) begin
      pend_a    <= request_byte_a;
      pend_b    <= request_byte_b;
      pend_c    <= request_byte_c;
      pend_ctrl <= ctrl_byte;
      pend_chk  <= bafe_pkg::HostLen ^ ctrl_byte ^ request_byte_a ^
                   request_byte_b ^ request_byte_c;
    end
    if (in_fire && reply_hit) begin
      for (int i = 0; i < 6; i++) begin
        pend_reply[i] <= win_next[i + 3];
      end
    end
  end

  logic is_tx;
  logic is_reply;
  logic [7:0] frame_byte;

  assign is_tx    = (pend_kind == bafe_pkg::KIND_TX);
  assign is_reply = (pend_kind == bafe_pkg::KIND_REPLY);

  always_comb begin
    case (pend_idx)
      3'd0:    frame_byte = bafe_pkg::HostStx;
      3'd1:    frame_byte = bafe_pkg::HostLen;
      3'd2:    frame_byte = pend_ctrl;
      3'd3:    frame_byte = pend_a;
      3'd4:    frame_byte = pend_b;
      3'd5:    frame_byte = pend_c;
      3'd6:    frame_byte = bafe_pkg::HostEtx;
      default: frame_byte = pend_chk;
    endcase
  end

  assign out_valid       = pend_valid;
  assign result_kind     = pend_kind;
  assign transmit_byte   = is_tx ? frame_byte : 8'd0;
  assign last_of_frame   = is_tx && (pend_idx == 3'd7);
  assign reply_state     = is_reply ? pend_reply[0] : 7'd0;
  assign reply_id        = is_reply ? pend_reply[1] : 7'd0;
  assign reply_bill_type = is_reply ? pend_reply[2] : 7'd0;
  assign reply_extra_a   = is_reply ? pend_reply[3] : 7'd0;
  assign reply_extra_b   = is_reply ? pend_reply[4] : 7'd0;
  assign reply_extra_c   = is_reply ? pend_reply[5] : 7'd0;

  // A request always leaves the engine waiting for a reply.
  a_request_arms: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == bafe_pkg::OP_REQUEST) |=> awaiting_reply)
    else $error("request transfer did not arm the reply wait");

  // Only a transmit group walks past its first result.
  a_idx_tx_only: assert property (@(posedge clk) disable iff (rst)
    pend_valid && (pend_idx != 3'd0) |-> (pend_kind == bafe_pkg::KIND_TX))
    else $error("result index advanced on a single-result group");

  // A reply or timeout ends the wait.
  a_result_ends_wait: assert property (@(posedge clk) disable iff (rst)
    in_fire && (reply_hit || timeout_hit) |=> !awaiting_reply)
    else $error("reply wait still active after its result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill <= 4'(bafe_pkg::WinLen))
    else $error("window fill count out of range");

endmodule
